// ----- sv/cfe_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfe_pkg
// shared constants and controller/datapath handshake types of the deframer
// ----------------------------------------------------------------------------
package cfe_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned WORD_W     = 32;
  localparam int unsigned WORD_BYTES = 4;
  localparam int unsigned WORD_COUNT = 6;
  localparam int unsigned OUT_BYTES  = WORD_COUNT * WORD_BYTES;
  localparam int unsigned OUT_W      = WORD_COUNT * WORD_W;

  // default frame layout
  localparam int unsigned FRAME_BYTES_DEF    = 31;
  localparam int unsigned PAYLOAD_START_DEF  = 6;
  localparam int unsigned PAYLOAD_BYTES_DEF  = 24;
  localparam int unsigned CHECK_POSITION_DEF = 30;

  // configuration registers
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_SYNC_FIRST  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SYNC_SECOND = 1'b1;

  localparam logic [BYTE_W-1:0] SYNC_FIRST_RST  = 8'hAA;
  localparam logic [BYTE_W-1:0] SYNC_SECOND_RST = 8'h55;

  // commands from controller to datapath
  typedef struct packed {
    logic append;     // write incoming byte behind the held bytes
    logic shift;      // drop the front byte
    logic settle;     // no header: keep only a trailing first sync byte
    logic sum_start;  // clear checksum accumulator and byte counter
    logic sum_step;   // add one payload byte
    logic emit;       // load output words and empty the window
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic hdr_front;  // header sits at the front of the window
    logic held_le1;   // at most one byte held
    logic full;       // a whole frame is held
    logic sum_last;   // current sum step adds the last payload byte
    logic match;      // accumulated sum equals the check byte
    logic out_busy;   // output register still holds an untaken item
  } sts_t;

endpackage

// ----- sv/checksummed_frame_extractor_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// checksummed_frame_extractor_core
// byte-serial deframer with two-byte sync header and additive checksum
// ----------------------------------------------------------------------------
// Received bytes enter one item per handshake on s_axis and collect in a
// window of FRAME_BYTES bytes. Bytes ahead of the sync header (sync_first
// then sync_second, set through the cfg port) are dropped one per cycle.
// When a whole frame is held from a header, the PAYLOAD_BYTES bytes from
// PAYLOAD_START are summed modulo 256, one byte per cycle, and compared with
// the byte at CHECK_POSITION. A match releases six little-endian 32-bit
// words on m_axis and empties the window; a mismatch drops one byte and the
// header search resumes. An item is accepted only while the sequencer is
// idle: a byte that completes nothing is appended and scanned, with any
// bytes ahead of a header shifted out of the front; a byte that completes
// a frame is also summed and checked, and on a mismatch the resync drops
// follow, before the next byte is taken. The checksum accumulator, stepping
// one window byte per cycle, sets the frame cost. The output register lets
// the next byte in while a released item waits; a second release waits
// until that item is taken.
// ----------------------------------------------------------------------------
module checksummed_frame_extractor_core #(
  parameter int unsigned FRAME_BYTES    = cfe_pkg::FRAME_BYTES_DEF,
  parameter int unsigned PAYLOAD_START  = cfe_pkg::PAYLOAD_START_DEF,
  parameter int unsigned PAYLOAD_BYTES  = cfe_pkg::PAYLOAD_BYTES_DEF,
  parameter int unsigned CHECK_POSITION = cfe_pkg::CHECK_POSITION_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // input bytes
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [cfe_pkg::BYTE_W-1:0]    s_axis_tdata,   // rx_byte[7:0]
  // released frames
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [cfe_pkg::OUT_W-1:0]     m_axis_tdata,   // word_0 .. word_5, 32 bits each
  // register writes
  input  logic                          cfg_we,
  input  logic [cfe_pkg::CFG_IDX_W-1:0] cfg_index,      // 0 sync_first, 1 sync_second
  input  logic [cfe_pkg::BYTE_W-1:0]    cfg_data
);

  cfe_pkg::cmd_t cmd;
  cfe_pkg::sts_t sts;

  // sequencer
  cfe_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // window, checksum and output register
  cfe_dp #(
    .FRAME_BYTES    (FRAME_BYTES),
    .PAYLOAD_START  (PAYLOAD_START),
    .PAYLOAD_BYTES  (PAYLOAD_BYTES),
    .CHECK_POSITION (CHECK_POSITION)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_byte   (s_axis_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

// ----- sv/cfe_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfe_ctrl
// sequencer: header scan, checksum accumulation and frame release
// ----------------------------------------------------------------------------
module cfe_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  cfe_pkg::sts_t sts,
  output cfe_pkg::cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_SUM   = 4'b0100,
    S_CHECK = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.append = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts.hdr_front) begin
          if (sts.full) begin
            cmd.sum_start = 1'b1;
            state_next    = S_SUM;
          end else begin
            state_next = S_IDLE;
          end
        end else if (sts.held_le1) begin
          cmd.settle = 1'b1;
          state_next = S_IDLE;
        end else begin
          cmd.shift = 1'b1;
        end
      end
      S_SUM: begin
        cmd.sum_step = 1'b1;
        if (sts.sum_last) begin
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.match) begin
          if (!sts.out_busy) begin
            cmd.emit   = 1'b1;
            state_next = S_IDLE;
          end
        end else begin
          // bad checksum: drop one byte and resume the header search
          cmd.shift  = 1'b1;
          state_next = S_SCAN;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  a_sum_needs_full: assert property (@(posedge clk) disable iff (rst)
    (state == S_SUM) |-> sts.full)
    else $error("checksum pass without a full frame");

  a_shift_keeps_byte: assert property (@(posedge clk) disable iff (rst)
    cmd.shift |-> !sts.held_le1)
    else $error("shift with at most one byte held");

  a_accept_scans: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == S_SCAN))
    else $error("accepted item not followed by a scan");

endmodule

// ----- sv/cfe_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfe_dp
// byte window, header compare, checksum accumulator and output register
// ----------------------------------------------------------------------------
module cfe_dp #(
  parameter int unsigned FRAME_BYTES    = cfe_pkg::FRAME_BYTES_DEF,
  parameter int unsigned PAYLOAD_START  = cfe_pkg::PAYLOAD_START_DEF,
  parameter int unsigned PAYLOAD_BYTES  = cfe_pkg::PAYLOAD_BYTES_DEF,
  parameter int unsigned CHECK_POSITION = cfe_pkg::CHECK_POSITION_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic [cfe_pkg::BYTE_W-1:0]       in_byte,
  input  logic                             cfg_we,
  input  logic [cfe_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [cfe_pkg::BYTE_W-1:0]       cfg_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [cfe_pkg::OUT_W-1:0]        out_data,
  input  cfe_pkg::cmd_t                    cmd,
  output cfe_pkg::sts_t                    sts
);

  localparam int unsigned HC_W  = $clog2(FRAME_BYTES + 1);
  localparam int unsigned IDX_W = $clog2(FRAME_BYTES);
  localparam int unsigned K_W   = $clog2(PAYLOAD_BYTES);
  localparam int unsigned POS_W = $clog2(PAYLOAD_START + PAYLOAD_BYTES + FRAME_BYTES + 1);

  logic [cfe_pkg::BYTE_W-1:0] window [FRAME_BYTES];
  logic [HC_W-1:0]            held;
  logic [cfe_pkg::BYTE_W-1:0] sync_first;
  logic [cfe_pkg::BYTE_W-1:0] sync_second;
  logic [cfe_pkg::BYTE_W-1:0] acc;
  logic [K_W-1:0]             k;

  logic [POS_W-1:0]           rd_pos;
  logic [cfe_pkg::BYTE_W-1:0] rd_byte;
  logic [cfe_pkg::BYTE_W-1:0] chk_byte;
  logic [cfe_pkg::OUT_W-1:0]  pay_flat;

  // payload read for the running sum; past the frame reads as zero
  assign rd_pos  = POS_W'(PAYLOAD_START) + POS_W'(k);
  assign rd_byte = (rd_pos < POS_W'(FRAME_BYTES)) ? window[rd_pos[IDX_W-1:0]] : '0;

  generate
    if (CHECK_POSITION < FRAME_BYTES) begin : g_chk
      assign chk_byte = window[CHECK_POSITION];
    end else begin : g_chk_zero
      assign chk_byte = '0;
    end

    for (genvar j = 0; j < cfe_pkg::OUT_BYTES; j++) begin : g_pay
      if (PAYLOAD_START + j < FRAME_BYTES) begin : g_in
        assign pay_flat[j*cfe_pkg::BYTE_W +: cfe_pkg::BYTE_W] = window[PAYLOAD_START + j];
      end else begin : g_out
        assign pay_flat[j*cfe_pkg::BYTE_W +: cfe_pkg::BYTE_W] = '0;
      end
    end
  endgenerate

  always_comb begin
    sts.hdr_front = (held >= HC_W'(2)) && (window[0] == sync_first)
                    && (window[1] == sync_second);
    sts.held_le1  = (held <= HC_W'(1));
    sts.full      = (held == HC_W'(FRAME_BYTES));
    sts.sum_last  = (k == K_W'(PAYLOAD_BYTES - 1));
    sts.match     = (acc == chk_byte);
    sts.out_busy  = out_valid && !out_ready;
  end

  // window storage: append at the fill point, shift toward the front
  always_ff @(posedge clk) begin
    if (cmd.append) begin
      window[held[IDX_W-1:0]] <= in_byte;
    end else if (cmd.shift) begin
      for (int i = 0; i < FRAME_BYTES - 1; i++) begin
        window[i] <= window[i + 1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= '0;
    end else if (cmd.append) begin
      held <= held + HC_W'(1);
    end else if (cmd.shift) begin
      held <= held - HC_W'(1);
    end else if (cmd.settle) begin
      if (!((held == HC_W'(1)) && (window[0] == sync_first))) begin
        held <= '0;
      end
    end else if (cmd.emit) begin
      held <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sum_start) begin
      acc <= '0;
      k   <= '0;
    end else if (cmd.sum_step) begin
      acc <= acc + rd_byte;
      k   <= k + K_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_first  <= cfe_pkg::SYNC_FIRST_RST;
      sync_second <= cfe_pkg::SYNC_SECOND_RST;
    end else if (cfg_we) begin
      if (cfg_index == cfe_pkg::REG_SYNC_FIRST) begin
        sync_first <= cfg_data;
      end
      if (cfg_index == cfe_pkg::REG_SYNC_SECOND) begin
        sync_second <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data <= pay_flat;
    end
  end

  a_held_bound: assert property (@(posedge clk) disable iff (rst)
    held <= HC_W'(FRAME_BYTES))
    else $error("window fill beyond frame length");

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> !(out_valid && !out_ready))
    else $error("frame released over an untaken item");

  a_emit_empties: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> (held == '0) && out_valid)
    else $error("window not emptied after frame release");

endmodule
